/* rtl/spi_mra_pkg.sv */
// types and constants shared by the spi register access core
package spi_mra_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_DIVIDER  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_PHASE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_POLARITY = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DUMMY_BYTE     = 2'd3;

    localparam logic [1:0] ACTION_TICK  = 2'd0;
    localparam logic [1:0] ACTION_READ  = 2'd1;
    localparam logic [1:0] ACTION_WRITE = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_READ,
        KIND_WRITE
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_GAP,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  addr_bytes;
        logic [1:0]  data_bytes;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [15:0] gap_ticks;
        logic        miso;
    } in_t;

    typedef struct packed {
        logic        sclk;
        logic        mosi;
        logic        select_active;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
    } out_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  addr_n;
        logic [1:0]  data_n;
        logic [15:0] address;
        logic [15:0] wdata;
        logic [15:0] gap;
        logic        miso;
    } cmd_t;

    typedef struct packed {
        logic        is_read;
        logic [1:0]  data_n;
        logic [15:0] address;
        logic [15:0] wdata;
        logic        cpha;
        logic        cpol;
    } req_t;

    typedef struct packed {
        logic [15:0] clock_divider;
        logic        clock_phase;
        logic        clock_polarity;
        logic [7:0]  dummy_byte;
    } cfg_t;

    typedef struct packed {
        logic valid;
    } cmd_ctrl_t;

endpackage

/* rtl/spi_master_register_access_core.sv */
// two register stages: the command queue entry and the output register
// throughput: one transfer per cycle while the output is not stalled, set by the single step serial engine
// a two entry command queue and the output register let each side stall alone
// reset: engine idle, divider register 1, other control registers 0; output data and queue entries not reset
module spi_master_register_access_core
#(
    parameter int DIVIDER_BITS = 16
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  spi_mra_pkg::in_t                           in_data,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output spi_mra_pkg::out_t                          out_data,
    input  logic                                       cfg_we,
    input  logic [spi_mra_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [spi_mra_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    spi_mra_pkg::cfg_t      cfg_reg;
    spi_mra_pkg::cfg_t      cfg_next;
    spi_mra_pkg::cmd_ctrl_t cmd_ctrl;
    spi_mra_pkg::cmd_t      cmd;
    logic                   cmd_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                spi_mra_pkg::CFG_CLOCK_DIVIDER:  cfg_next.clock_divider  = cfg_data;
                spi_mra_pkg::CFG_CLOCK_PHASE:    cfg_next.clock_phase    = cfg_data[0];
                spi_mra_pkg::CFG_CLOCK_POLARITY: cfg_next.clock_polarity = cfg_data[0];
                spi_mra_pkg::CFG_DUMMY_BYTE:     cfg_next.dummy_byte     = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_divider  <= 16'd1;
            cfg_reg.clock_phase    <= 1'b0;
            cfg_reg.clock_polarity <= 1'b0;
            cfg_reg.dummy_byte     <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spi_mra_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .cmd_ctrl_out (cmd_ctrl),
        .cmd_pop      (cmd_pop),
        .cmd          (cmd)
    );

    spi_mra_back
    #(
        .DIVIDER_BITS (DIVIDER_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_ctrl  (cmd_ctrl),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* rtl/spi_mra_queue.sv */
// two entry command queue between front and back
module spi_mra_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spi_mra_pkg::cmd_t   push_data,
    output logic                full,
    output logic                not_empty,
    input  logic                pop,
    output spi_mra_pkg::cmd_t   pop_data
);

    spi_mra_pkg::cmd_t entry_reg [spi_mra_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push_ok;
    logic       pop_ok;

    assign full      = (count_reg == 2'(spi_mra_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push_ok ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_ok ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push_ok} - {1'b0, pop_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/spi_mra_front.sv */
// front end: accepts input transfers, classifies them and queues commands
module spi_mra_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  spi_mra_pkg::in_t      in_data,
    output spi_mra_pkg::cmd_ctrl_t cmd_ctrl_out,
    input  logic                  cmd_pop,
    output spi_mra_pkg::cmd_t     cmd
);

    spi_mra_pkg::cmd_t classified;
    logic              q_full;
    logic              q_not_empty;

    always_comb
    begin
        case (in_data.action)
            spi_mra_pkg::ACTION_READ:  classified.kind = spi_mra_pkg::KIND_READ;
            spi_mra_pkg::ACTION_WRITE: classified.kind = spi_mra_pkg::KIND_WRITE;
            default:                   classified.kind = spi_mra_pkg::KIND_TICK;
        endcase
        classified.addr_n  = (in_data.addr_bytes == 2'd3) ? 2'd2 : in_data.addr_bytes;
        case (in_data.data_bytes)
            2'd0:    classified.data_n = 2'd1;
            2'd3:    classified.data_n = 2'd2;
            default: classified.data_n = in_data.data_bytes;
        endcase
        classified.address = in_data.address;
        classified.wdata   = in_data.write_data;
        classified.gap     = in_data.gap_ticks;
        classified.miso    = in_data.miso;
    end

    assign in_stall = q_full;

    spi_mra_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (classified),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (cmd_pop),
        .pop_data  (cmd)
    );

    assign cmd_ctrl_out.valid = q_not_empty;

endmodule

/* rtl/spi_mra_back.sv */
// back end: serial engine that carries out queued commands, one per cycle while the output is not stalled
module spi_mra_back
#(
    parameter int DIVIDER_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  spi_mra_pkg::cfg_t      cfg,
    input  spi_mra_pkg::cmd_ctrl_t cmd_ctrl,
    input  spi_mra_pkg::cmd_t      cmd,
    output logic                   cmd_pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output spi_mra_pkg::out_t      out_data
);

    localparam int EXT_BITS = (DIVIDER_BITS > 16) ? DIVIDER_BITS : 16;

    function automatic logic [7:0] pick_byte(input logic is_addr, input logic [1:0] left,
                                             input spi_mra_pkg::req_t rq,
                                             input logic [7:0] dummy);
        logic [7:0] b;
        if (is_addr)
            b = (left == 2'd2) ? rq.address[15:8] : rq.address[7:0];
        else if (rq.is_read)
            b = dummy;
        else
            b = (left == 2'd2) ? rq.wdata[15:8] : rq.wdata[7:0];
        return b;
    endfunction

    spi_mra_pkg::phase_t    phase_reg, phase_next;
    spi_mra_pkg::req_t      req_reg, req_next;
    logic [7:0]             out_shift_reg, out_shift_next;
    logic [15:0]            in_shift_reg, in_shift_next;
    logic [3:0]             bit_index_reg, bit_index_next;
    logic [1:0]             bytes_left_reg, bytes_left_next;
    logic [DIVIDER_BITS-1:0] div_count_reg, div_count_next;
    logic [15:0]            gap_reg, gap_next;
    logic                   clock_level_reg, clock_level_next;
    logic                   out_valid_reg, out_valid_next;
    spi_mra_pkg::out_t      out_data_reg, out_data_next;
    logic                   done;
    logic [EXT_BITS-1:0]    div_ext;
    logic [DIVIDER_BITS-1:0] div_eff;
    logic [DIVIDER_BITS-1:0] div_cnt;
    logic                   active;
    logic [3:0]             bit_inc;
    logic [1:0]             bytes_dec;
    logic [15:0]            gap_dec;

    assign cmd_pop = cmd_ctrl.valid && (!out_valid_reg || !out_stall);

    assign div_ext = EXT_BITS'(cfg.clock_divider);
    assign div_eff = (div_ext[DIVIDER_BITS-1:0] == '0) ? DIVIDER_BITS'(1)
                                                        : div_ext[DIVIDER_BITS-1:0];
    assign div_cnt = div_count_reg + DIVIDER_BITS'(1);
    assign bit_inc = bit_index_reg + 4'd1;
    assign bytes_dec = (bytes_left_reg != 2'd0) ? bytes_left_reg - 2'd1 : bytes_left_reg;
    assign gap_dec = (gap_reg != 16'd0) ? gap_reg - 16'd1 : gap_reg;

    // next state
    always_comb
    begin
        phase_next       = phase_reg;
        req_next         = req_reg;
        out_shift_next   = out_shift_reg;
        in_shift_next    = in_shift_reg;
        bit_index_next   = bit_index_reg;
        bytes_left_next  = bytes_left_reg;
        div_count_next   = div_count_reg;
        gap_next         = gap_reg;
        clock_level_next = clock_level_reg;
        done             = 1'b0;
        if (cmd_pop)
        begin
            case (cmd.kind)
                spi_mra_pkg::KIND_READ, spi_mra_pkg::KIND_WRITE:
                begin
                    if (phase_reg == spi_mra_pkg::PH_IDLE)
                    begin
                        req_next.is_read = (cmd.kind == spi_mra_pkg::KIND_READ);
                        req_next.data_n  = cmd.data_n;
                        req_next.address = cmd.address;
                        req_next.wdata   = cmd.wdata;
                        req_next.cpha    = cfg.clock_phase;
                        req_next.cpol    = cfg.clock_polarity;
                        gap_next         = cmd.gap;
                        in_shift_next    = '0;
                        out_shift_next   = '0;
                        bit_index_next   = '0;
                        div_count_next   = '0;
                        clock_level_next = cfg.clock_polarity;
                        if (cmd.addr_n != 2'd0)
                        begin
                            phase_next      = spi_mra_pkg::PH_ADDR;
                            bytes_left_next = cmd.addr_n;
                            out_shift_next  = pick_byte(1'b1, cmd.addr_n, req_next,
                                                        cfg.dummy_byte);
                        end
                        else if (cmd.gap != 16'd0)
                        begin
                            phase_next = spi_mra_pkg::PH_GAP;
                        end
                        else
                        begin
                            phase_next      = spi_mra_pkg::PH_DATA;
                            bytes_left_next = cmd.data_n;
                            out_shift_next  = pick_byte(1'b0, cmd.data_n, req_next,
                                                        cfg.dummy_byte);
                        end
                    end
                end
                default:
                begin
                    case (phase_reg)
                        spi_mra_pkg::PH_ADDR, spi_mra_pkg::PH_DATA:
                        begin
                            if (div_cnt < div_eff)
                            begin
                                div_count_next = div_cnt;
                            end
                            else
                            begin
                                div_count_next   = '0;
                                clock_level_next = ~clock_level_reg;
                                if (clock_level_reg == req_reg.cpol)
                                begin
                                    // leading edge
                                    if (req_reg.cpha)
                                    begin
                                        if (phase_reg == spi_mra_pkg::PH_DATA)
                                            in_shift_next = {in_shift_reg[14:0], cmd.miso};
                                    end
                                    else if (bit_index_reg != 4'd0)
                                    begin
                                        out_shift_next = {out_shift_reg[6:0], 1'b0};
                                    end
                                end
                                else
                                begin
                                    // trailing edge
                                    if (req_reg.cpha)
                                        out_shift_next = {out_shift_reg[6:0], 1'b0};
                                    else if (phase_reg == spi_mra_pkg::PH_DATA)
                                        in_shift_next = {in_shift_reg[14:0], cmd.miso};
                                    bit_index_next = bit_inc;
                                    if (bit_inc >= spi_mra_pkg::BITS_PER_BYTE)
                                    begin
                                        bit_index_next  = '0;
                                        bytes_left_next = bytes_dec;
                                        if (bytes_dec != 2'd0)
                                        begin
                                            out_shift_next = pick_byte(
                                                phase_reg == spi_mra_pkg::PH_ADDR,
                                                bytes_dec, req_reg, cfg.dummy_byte);
                                            clock_level_next = req_reg.cpol;
                                        end
                                        else if (phase_reg == spi_mra_pkg::PH_ADDR)
                                        begin
                                            if (gap_reg != 16'd0)
                                            begin
                                                phase_next = spi_mra_pkg::PH_GAP;
                                            end
                                            else
                                            begin
                                                phase_next       = spi_mra_pkg::PH_DATA;
                                                bytes_left_next  = req_reg.data_n;
                                                in_shift_next    = '0;
                                                out_shift_next   = pick_byte(1'b0,
                                                    req_reg.data_n, req_reg, cfg.dummy_byte);
                                                clock_level_next = req_reg.cpol;
                                            end
                                        end
                                        else
                                        begin
                                            phase_next = spi_mra_pkg::PH_IDLE;
                                            done       = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        spi_mra_pkg::PH_GAP:
                        begin
                            gap_next = gap_dec;
                            if (gap_dec == 16'd0)
                            begin
                                phase_next       = spi_mra_pkg::PH_DATA;
                                bytes_left_next  = req_reg.data_n;
                                in_shift_next    = '0;
                                out_shift_next   = pick_byte(1'b0, req_reg.data_n, req_reg,
                                                             cfg.dummy_byte);
                                bit_index_next   = '0;
                                div_count_next   = '0;
                                clock_level_next = req_reg.cpol;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        active = (phase_next != spi_mra_pkg::PH_IDLE);
        out_data_next.sclk          = active ? clock_level_next : cfg.clock_polarity;
        out_data_next.mosi          = active ? out_shift_next[7] : 1'b0;
        out_data_next.select_active = active;
        out_data_next.busy_res      = active;
        out_data_next.done_res      = done;
        out_data_next.read_data     = done ? in_shift_next : 16'd0;
        if (cmd_pop)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= spi_mra_pkg::PH_IDLE;
            req_reg         <= '0;
            out_shift_reg   <= '0;
            in_shift_reg    <= '0;
            bit_index_reg   <= '0;
            bytes_left_reg  <= '0;
            div_count_reg   <= '0;
            gap_reg         <= '0;
            clock_level_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            req_reg         <= req_next;
            out_shift_reg   <= out_shift_next;
            in_shift_reg    <= in_shift_next;
            bit_index_reg   <= bit_index_next;
            bytes_left_reg  <= bytes_left_next;
            div_count_reg   <= div_count_next;
            gap_reg         <= gap_next;
            clock_level_reg <= clock_level_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
